FILE: rtl/lr_pkg.sv
// Shared types and constants for the Bresenham line rasteriser.
// Holds the coordinate widths, the item kind codes and the command record
// that travels from the front part through the queue to the back part.
package lr_pkg;

   // Width of one pixel coordinate.
   localparam int COORD_BITS = 10;
   // Colour of a pixel, 24-bit RGB.
   localparam int COLOR_BITS = 24;
   // Signed decision term: it spans roughly plus or minus twice the major delta.
   localparam int DEC_BITS = COORD_BITS + 3;

   // Command queue between the front and back parts.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // Item kinds carried on the request channel.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;
   typedef logic signed [DEC_BITS-1:0] decision_type;

   // One classified command. For a tick only the kind is meaningful.
   typedef struct packed {
      logic      kind;
      logic      steep;
      logic      minor_step_negative;
      coord_type first_x;
      coord_type first_y;
      coord_type major_end;
      coord_type major_delta;
      coord_type minor_delta;
      color_type color;
   } lr_cmd_type;

   // What the back part reports about its own progress.
   typedef struct packed {
      logic active;
      logic emit;
      logic emit_last;
      logic load;
   } lr_back_status_type;

endpackage

FILE: rtl/lr_channels.sv
// Valid/ready channel interfaces for the line rasteriser.
// Depends on lr_pkg for the coordinate and colour widths.

// Request channel: a start item with endpoints and colour, or a tick.
interface lr_req_if;
   import lr_pkg::*;
   logic      valid;
   logic      ready;
   logic      kind;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;
   color_type line_color;

   modport source (output valid, kind, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink   (input valid, kind, start_x, start_y, end_x, end_y, line_color,
                   output ready);
endinterface

// Response channel: one pixel per beat.
interface lr_rsp_if;
   import lr_pkg::*;
   logic      valid;
   logic      ready;
   coord_type pixel_x;
   coord_type pixel_y;
   color_type pixel_color;
   logic      last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

FILE: rtl/lr_front.sv
// Front part of the line rasteriser: accepts request beats and classifies them.
// A start item is turned into a ready-made line setup. Depends on lr_pkg.
module lr_front
   import lr_pkg::*;
(
   lr_req_if.sink     req_ch,
   input  logic       cmd_ready,
   output logic       cmd_push,
   output lr_cmd_type cmd
);

   coord_type adx;
   coord_type ady;
   logic      steep;
   logic      swap;
   coord_type fst_x;
   coord_type fst_y;
   coord_type sec_x;
   coord_type sec_y;

   // A beat is taken whenever the queue has room.
   assign req_ch.ready = cmd_ready;
   assign cmd_push     = req_ch.valid && cmd_ready;

   // Absolute deltas and the branch choice; equal slopes go steep.
   always_comb begin
      adx   = (req_ch.end_x >= req_ch.start_x) ? req_ch.end_x - req_ch.start_x
                                               : req_ch.start_x - req_ch.end_x;
      ady   = (req_ch.end_y >= req_ch.start_y) ? req_ch.end_y - req_ch.start_y
                                               : req_ch.start_y - req_ch.end_y;
      steep = !(ady < adx);
      swap  = steep ? (req_ch.start_y > req_ch.end_y) : (req_ch.start_x > req_ch.end_x);
      fst_x = swap ? req_ch.end_x : req_ch.start_x;
      fst_y = swap ? req_ch.end_y : req_ch.start_y;
      sec_x = swap ? req_ch.start_x : req_ch.end_x;
      sec_y = swap ? req_ch.start_y : req_ch.end_y;
   end

   // Build the command record so the major axis counts upward.
   always_comb begin
      cmd.kind                = req_ch.kind;
      cmd.steep               = steep;
      cmd.minor_step_negative = steep ? (sec_x < fst_x) : (sec_y < fst_y);
      cmd.first_x             = fst_x;
      cmd.first_y             = fst_y;
      cmd.major_end           = steep ? sec_y : sec_x;
      cmd.major_delta         = steep ? ady : adx;
      cmd.minor_delta         = steep ? adx : ady;
      cmd.color               = req_ch.line_color;
   end

endmodule

FILE: rtl/lr_cmd_queue.sv
// Short command queue that decouples the front and back parts.
// Register-based, one write and one read per cycle. Depends on lr_pkg.
module lr_cmd_queue
   import lr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  lr_cmd_type push_cmd,
   output logic       push_ready,
   input  logic       pop,
   output logic       pop_valid,
   output lr_cmd_type pop_cmd
);

   lr_cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff;
   logic [QUEUE_PTR_BITS:0]   count_in;

   assign push_ready = (count_ff != QUEUE_DEPTH[QUEUE_PTR_BITS:0]);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/lr_back.sv
// Back part of the line rasteriser: holds the running line, steps the
// Bresenham error term and drives the registered pixel output. Depends on lr_pkg.
module lr_back
   import lr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  lr_cmd_type         cmd,
   output logic               cmd_pop,
   output lr_back_status_type status,
   lr_rsp_if.source           rsp_ch
);

   logic         active_ff;
   logic         active_in;
   logic         steep_ff;
   logic         steep_in;
   logic         neg_ff;
   logic         neg_in;
   coord_type    cur_x_ff;
   coord_type    cur_x_in;
   coord_type    cur_y_ff;
   coord_type    cur_y_in;
   coord_type    major_end_ff;
   coord_type    major_end_in;
   coord_type    major_delta_ff;
   coord_type    major_delta_in;
   coord_type    minor_delta_ff;
   coord_type    minor_delta_in;
   decision_type decision_ff;
   decision_type decision_in;
   color_type    color_ff;
   color_type    color_in;

   logic         out_valid_ff;
   logic         out_valid_in;
   coord_type    out_x_ff;
   coord_type    out_y_ff;
   color_type    out_color_ff;
   logic         out_last_ff;

   logic         out_free;
   logic         is_start;
   logic         emit;
   logic         is_last;
   coord_type    major;
   coord_type    minor;
   coord_type    minor_next;
   decision_type twice_minor;
   decision_type twice_major;

   // A command is taken unless a pixel must go out and the output is still full.
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign is_start = (cmd.kind == KIND_START);
   assign cmd_pop  = cmd_valid && (is_start || !active_ff || out_free);
   assign emit     = cmd_pop && !is_start && active_ff;

   // Current position seen along the major and minor axes.
   always_comb begin
      major       = steep_ff ? cur_y_ff : cur_x_ff;
      minor       = steep_ff ? cur_x_ff : cur_y_ff;
      is_last     = (major == major_end_ff);
      twice_minor = decision_type'({2'b00, minor_delta_ff, 1'b0});
      twice_major = decision_type'({2'b00, major_delta_ff, 1'b0});
   end

   // Line state: load on a start, step on an emitted pixel.
   always_comb begin
      active_in      = active_ff;
      steep_in       = steep_ff;
      neg_in         = neg_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      major_end_in   = major_end_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      decision_in    = decision_ff;
      color_in       = color_ff;
      minor_next     = minor;
      if (cmd_pop && is_start) begin
         active_in      = 1'b1;
         steep_in       = cmd.steep;
         neg_in         = cmd.minor_step_negative;
         cur_x_in       = cmd.first_x;
         cur_y_in       = cmd.first_y;
         major_end_in   = cmd.major_end;
         major_delta_in = cmd.major_delta;
         minor_delta_in = cmd.minor_delta;
         color_in       = cmd.color;
         decision_in    = decision_type'({2'b00, cmd.minor_delta, 1'b0})
                          - decision_type'({3'b000, cmd.major_delta});
      end else if (emit) begin
         if (is_last) begin
            active_in = 1'b0;
         end else begin
            if (!decision_ff[DEC_BITS-1] && (decision_ff != '0)) begin
               minor_next  = neg_ff ? minor - 1'b1 : minor + 1'b1;
               decision_in = decision_ff + twice_minor - twice_major;
            end else begin
               decision_in = decision_ff + twice_minor;
            end
            if (steep_ff) begin
               cur_y_in = major + 1'b1;
               cur_x_in = minor_next;
            end else begin
               cur_x_in = major + 1'b1;
               cur_y_in = minor_next;
            end
         end
      end
   end

   // Output register: loaded on an emitted pixel, cleared when the beat is taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      steep_ff       <= steep_in;
      neg_ff         <= neg_in;
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      major_end_ff   <= major_end_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      decision_ff    <= decision_in;
      color_ff       <= color_in;
      if (emit) begin
         out_x_ff     <= cur_x_ff;
         out_y_ff     <= cur_y_ff;
         out_color_ff <= color_ff;
         out_last_ff  <= is_last;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.pixel_x     = out_x_ff;
   assign rsp_ch.pixel_y     = out_y_ff;
   assign rsp_ch.pixel_color = out_color_ff;
   assign rsp_ch.last        = out_last_ff;

   assign status.active    = active_ff;
   assign status.emit      = emit;
   assign status.emit_last = emit && is_last;
   assign status.load      = cmd_pop && is_start;

endmodule

FILE: rtl/line_rasterizer_core.sv
// Top level of the Bresenham line rasteriser, all octants.
// Instantiates lr_front, lr_cmd_queue and lr_back; depends on lr_pkg and the channels.
//
// Usage:
//   req_ch carries one item per beat. A start item (kind 0) loads two endpoints
//   and a colour and produces no pixel; a later start abandons a running line.
//   Each tick item (kind 1) produces the next pixel of the line on rsp_ch,
//   with last set on the final one, after which the block is idle again.
//   A tick while idle produces nothing.
//   The front part classifies each beat and works out the line setup, a
//   four-entry command queue holds classified items, and the back part steps
//   the error term by adding the doubled deltas after testing whether it is positive, per pixel.
//   A tick accepted on req_ch is written into the queue; once it is at the
//   head of the queue and the output has room, its pixel is written into the
//   output register that drives rsp_ch, where the receiver can take it.
//   Throughput: one item per cycle, and so one pixel per cycle during a line, while the receiver does not stall.
//   When the receiver stalls the output register holds its pixel, the back part
//   stops at the next tick, the queue fills, and req_ch.ready falls once the
//   queue is full. Start items still drain from the queue during a stall.
//   Reset is synchronous and active high: it empties the queue, drops the
//   running line and clears the output; the block is ready in the next cycle.
module line_rasterizer_core
   import lr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   lr_req_if.sink   req_ch,
   lr_rsp_if.source rsp_ch
);

   lr_cmd_type         push_cmd;
   lr_cmd_type         pop_cmd;
   logic               push;
   logic               push_ready;
   logic               pop;
   logic               pop_valid;
   lr_back_status_type back_status;

   // Classification and line setup.
   lr_front u_front (
      .req_ch    (req_ch),
      .cmd_ready (push_ready),
      .cmd_push  (push),
      .cmd       (push_cmd)
   );

   // Decoupling queue.
   lr_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   // Line stepping and pixel output.
   lr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_pop   (pop),
      .status    (back_status),
      .rsp_ch    (rsp_ch)
   );

   // A pixel is only written into the output register when it has room.
   assert property (@(posedge clock) disable iff (reset)
      back_status.emit |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("pixel written over an untaken output beat");

   // The final pixel of a line leaves the back part idle.
   assert property (@(posedge clock) disable iff (reset)
      back_status.emit_last |=> !back_status.active)
      else $error("line still active after its final pixel");

   // A loaded line is active in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      back_status.load |=> back_status.active)
      else $error("start item did not activate the line");

   // Every emitted pixel shows up as a valid output beat.
   assert property (@(posedge clock) disable iff (reset)
      back_status.emit |=> rsp_ch.valid)
      else $error("emitted pixel missing from the output");

endmodule
